FILE: rtl/core/prf_pkg.sv
// Shared constants and types for the page replacement unit.
package prf_pkg;

	localparam int FRAME_COUNT = 3;
	localparam int PAGE_BITS   = 8;
	localparam int PAGE_PORT_W = 8;
	localparam int STORE_W     = (PAGE_BITS < PAGE_PORT_W) ? PAGE_BITS : PAGE_PORT_W;
	localparam int FAULT_W     = 16;
	localparam int APB_ADDR_W  = 2;
	localparam int APB_DATA_W  = 32;

	localparam logic [APB_ADDR_W-1:0] ADDR_POLICY = APB_ADDR_W'(0);

	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	typedef logic [STORE_W-1:0] page_t;

	// Contents of one cell as its neighbours see them.
	typedef struct packed {
		logic  valid;
		page_t page;
	} cell_view_t;

	// Broadcast control common to every cell of the row.
	typedef struct packed {
		logic  step;
		logic  lru;
		logic  miss;
		page_t page;
	} cell_ctl_t;

endpackage

FILE: rtl/core/prf_cell.sv
// One position of the age-ordered frame row: holds a page and shifts towards the oldest end.
module prf_cell import prf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  cell_view_t next_view,
	input  logic       prev_valid,
	input  logic       remove_in,
	output cell_view_t view,
	output logic       match,
	output logic       remove_out
);

	logic  valid_q;
	page_t page_q;
	logic  fill;
	logic  take_next;
	logic  load_new;

	assign match      = valid_q & (page_q == ctl.page);
	// Removal spreads from the hit (LRU) or from the oldest cell (eviction) upwards.
	assign remove_out = remove_in | (match & ctl.lru);
	// The lowest empty cell takes a fresh page on a miss.
	assign fill       = ctl.miss & ~valid_q & prev_valid;
	assign take_next  = ctl.step & valid_q & remove_out & next_view.valid;
	assign load_new   = ctl.step & ((valid_q & remove_out & ~next_view.valid) | fill);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_new) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_next) begin
			page_q <= next_view.page;
		end else if (load_new) begin
			page_q <= ctl.page;
		end
	end

	assign view = '{valid: valid_q, page: page_q};

endmodule

FILE: rtl/core/page_replacement_fifo_lru.sv
// Top level of the FIFO / LRU page replacement unit.
//
//  channel   | signals                                      | flow
//  ----------+----------------------------------------------+-------------------------------
//  request   | start, busy, page_number                     | taken when start high, busy low
//  result    | done, hit, evicted_valid, evicted_page,      | one word per request, shown for
//            | fault_total                                  | exactly one cycle with done
//  config    | psel, penable, pwrite, paddr, pwdata,        | APB-style, no wait states
//            | prdata, pready                               |
//
// A request is taken in any cycle, and its result word appears with done in the following
// cycle, so one page reference per clock is sustained. The figure is set by the row of
// cells: every reference is compared with all cells and the row shifts in the same cycle.
// busy is held low, since the row is ready again at every edge.
// After reset all frames are empty, the policy is FIFO and the fault count is zero.
// The receiver cannot hold results off, so no result is ever stalled.
module page_replacement_fifo_lru import prf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [PAGE_PORT_W-1:0] page_number,
	output logic                   done,
	output logic                   hit,
	output logic                   evicted_valid,
	output logic [PAGE_PORT_W-1:0] evicted_page,
	output logic [FAULT_W-1:0]     fault_total,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	// The row is ordered by age: cell 0 holds the oldest page, the newest sits at the top of
	// the filled part. A hit in LRU mode pulls its page out and re-inserts it at the newest
	// end; a fault with a full row drops cell 0 and appends the new page at the top.

	logic                   policy_q;
	logic                   step;
	logic                   any_hit;
	logic                   miss;
	logic                   row_full;
	logic                   evict_now;
	cell_ctl_t              ctl;
	cell_view_t             views [FRAME_COUNT];
	logic [FRAME_COUNT-1:0] match_vec;
	logic [FRAME_COUNT:0]   remove_chain;

	logic                   done_q;
	logic                   hit_q;
	logic                   evict_valid_q;
	logic [PAGE_PORT_W-1:0] evict_page_q;
	logic [FAULT_W-1:0]     fault_q;

	assign busy      = 1'b0;
	assign step      = start & ~busy;
	assign any_hit   = |match_vec;
	assign miss      = step & ~any_hit;
	assign row_full  = views[FRAME_COUNT-1].valid;
	assign evict_now = miss & row_full;

	assign ctl = '{step: step, lru: (policy_q == POLICY_LRU), miss: miss,
		page: page_number[STORE_W-1:0]};

	// An eviction starts the shift at the oldest cell.
	assign remove_chain[0] = evict_now;

	for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_cell
		cell_view_t next_view;
		logic       prev_valid;

		if (i == FRAME_COUNT - 1) begin : g_top
			assign next_view = '0;
		end else begin : g_mid
			assign next_view = views[i+1];
		end

		if (i == 0) begin : g_base
			assign prev_valid = 1'b1;
		end else begin : g_upper
			assign prev_valid = views[i-1].valid;
		end

		prf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.next_view  (next_view),
			.prev_valid (prev_valid),
			.remove_in  (remove_chain[i]),
			.view       (views[i]),
			.match      (match_vec[i]),
			.remove_out (remove_chain[i+1])
		);
	end

	// Result word and saturating fault count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			fault_q <= '0;
		end else begin
			done_q <= step;
			if (miss && (fault_q != {FAULT_W{1'b1}})) begin
				fault_q <= fault_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			hit_q         <= any_hit;
			evict_valid_q <= evict_now;
			evict_page_q  <= evict_now ? PAGE_PORT_W'(views[0].page) : '0;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign evicted_valid = evict_valid_q;
	assign evicted_page  = evict_page_q;
	assign fault_total   = fault_q;

	// Configuration register: only the policy bit exists.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_FIFO;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_POLICY)) begin
			policy_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_POLICY) ? APB_DATA_W'(policy_q) : '0;

endmodule

FILE: rtl/core/prf_checker.sv
// Port-level checks for the page replacement unit, bound to its top level.
module prf_checker import prf_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic                   hit,
	input logic                   evicted_valid,
	input logic [PAGE_PORT_W-1:0] evicted_page,
	input logic [FAULT_W-1:0]     fault_total
);

	// Every accepted word yields exactly one result word in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (done == $past(start && !busy)))
		else $error("result strobe does not follow accepted word");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> !evicted_valid)
		else $error("eviction reported on a hit");

	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !evicted_valid) |-> (evicted_page == '0))
		else $error("evicted page not zero without eviction");

	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (fault_total != '0))
		else $error("fault not counted");

	a_count_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit && $past(done)) |-> $stable(fault_total))
		else $error("fault count moved on a hit");

endmodule

bind page_replacement_fifo_lru prf_checker u_prf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.hit           (hit),
	.evicted_valid (evicted_valid),
	.evicted_page  (evicted_page),
	.fault_total   (fault_total)
);
